// ===== rtl/woi_pkg.sv =====
`timescale 1ns / 1ps

package woi_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_KIN,
		S_TURN,
		S_DIV,
		S_MOD,
		S_HEAD,
		S_CSET,
		S_CORDIC,
		S_CFIN,
		S_POS,
		S_DONE
	} state_t;

	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_TWO_WHEEL = 3'd1;
	localparam logic [2:0] KIND_TWO_OMNI  = 3'd2;
	localparam logic [2:0] KIND_THREE     = 3'd3;
	localparam logic [2:0] KIND_FOUR      = 3'd4;
	localparam logic [2:0] KIND_MECANUM   = 3'd5;

	localparam logic [1:0] REG_KIND   = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_BODY   = 2'd2;
	localparam logic [1:0] REG_SPAN   = 2'd3;

	localparam int FULL_TURN    = 23040;
	localparam int HALF_TURN    = 11520;
	localparam int QUARTER_TURN = 5760;
	localparam int ATAN_ENTRIES = 24;

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic signed [22:0] COS15 = 23'sd63303;
	localparam logic signed [22:0] COS45 = 23'sd46341;
	localparam logic signed [22:0] COS75 = 23'sd16962;

	// 180*64/pi in Q16, split as high*2^14 + low
	localparam logic signed [22:0] DEG_K_HI = 23'sd14667;
	localparam logic signed [22:0] DEG_K_LO = 23'sd11789;

	function automatic logic [29:0] atan_q24(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd754974720;
			5'd1:  v = 30'd445687602;
			5'd2:  v = 30'd235489089;
			5'd3:  v = 30'd119537938;
			5'd4:  v = 30'd60000934;
			5'd5:  v = 30'd30029717;
			5'd6:  v = 30'd15018523;
			5'd7:  v = 30'd7509720;
			5'd8:  v = 30'd3754917;
			5'd9:  v = 30'd1877466;
			5'd10: v = 30'd938734;
			5'd11: v = 30'd469367;
			5'd12: v = 30'd234684;
			5'd13: v = 30'd117342;
			5'd14: v = 30'd58671;
			5'd15: v = 30'd29335;
			5'd16: v = 30'd14668;
			5'd17: v = 30'd7334;
			5'd18: v = 30'd3667;
			5'd19: v = 30'd1833;
			5'd20: v = 30'd917;
			5'd21: v = 30'd458;
			5'd22: v = 30'd229;
			5'd23: v = 30'd115;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/wheel_odometry_integrator_unit.sv =====
`timescale 1ns / 1ps

// Wheel odometry integrator.
// Input stream: one request per control tick with four wheel increments and
// a yaw; output stream: one result (X, Y, heading) per request, in order.
// Configuration is written over the APB port. The user must write it only
// while the block is idle; the block itself does not enforce this.
// One shared 36x23 multiplier does every product; the turn goes through a
// 35-step restoring divider and a 22-step modulo reduction, and sin/cos come
// from one CORDIC stage iterated N = min(CORDIC_STEPS, 24) times.
// s_tready is high only while the sequencer is idle, so a new request is not
// taken until the previous result has moved into the output register. A
// finished result waits in the output register; a new request is taken
// meanwhile, and the sequencer holds its result until the register frees up.
// Reset clears position, heading and registers to their defaults.
module wheel_odometry_integrator_unit
	import woi_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// wheel_a[15:0], wheel_b[31:16], wheel_c[47:32], wheel_d[63:48], yaw_in[78:64]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pos_x[31:0], pos_y[63:32], heading_out[78:64]
	output logic [79:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam logic [5:0] CORDIC_LAST = 6'(NSTEPS - 1);
	localparam logic [5:0] DIV_LAST = 6'd34;
	localparam logic [5:0] MOD_FIRST = 6'd21;

	state_t state_q, state_d;

	logic [5:0] cnt_q;
	logic       ph_q;

	logic [2:0]  kind_q;
	logic [15:0] rad_q, body_q, span_q;

	logic signed [15:0] w0_q, w1_q, w2_q, w3_q;
	logic signed [14:0] yaw_q;

	logic signed [33:0] t0_q, t1_q, t2_q;
	logic signed [63:0] acc64_q;
	logic signed [37:0] rx_q, ry_q;
	logic signed [35:0] num_q;
	logic signed [58:0] prod_q;
	logic [18:0] rem_q;
	logic [34:0] quo_q;
	logic signed [32:0] x_q, y_q, z_q;
	logic flip_q;
	logic signed [21:0] cos_q, sin_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic signed [15:0] acc_h_q;
	logic [31:0] ox_q, oy_q;
	logic [14:0] oh_q;
	logic m_valid_q;

	logic in_acc, out_free, is_three, yaw_kind, turn_kind, move_kind;
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign is_three = (kind_q == KIND_THREE);
	assign yaw_kind = (kind_q == KIND_TWO_WHEEL) || (kind_q == KIND_TWO_OMNI);
	assign turn_kind = is_three || (kind_q == KIND_FOUR) || (kind_q == KIND_MECANUM);
	assign move_kind = yaw_kind || turn_kind;

	// ---------------- wheel combinations and divisor ----------------
	logic signed [17:0] lin_x, lin_y, lin_n;
	logic [5:0] shx;
	logic [15:0] l_eff, s_eff;
	logic [17:0] divr;

	always_comb begin
		lin_x = '0;
		lin_y = '0;
		lin_n = '0;
		shx = 6'd0;
		case (kind_q)
			KIND_TWO_WHEEL: begin
				lin_x = 18'(w0_q) + 18'(w1_q);
				shx = 6'd3;
			end
			KIND_TWO_OMNI: begin
				lin_x = 18'(w0_q);
				lin_y = 18'(w1_q);
				shx = 6'd4;
			end
			KIND_FOUR: begin
				lin_x = 18'(w3_q) - 18'(w1_q);
				lin_y = 18'(w0_q) - 18'(w2_q);
				lin_n = 18'(w0_q) + 18'(w1_q) + 18'(w2_q) + 18'(w3_q);
				shx = 6'd4;
			end
			KIND_MECANUM: begin
				lin_x = 18'(w0_q) + 18'(w1_q) + 18'(w2_q) + 18'(w3_q);
				lin_y = 18'(w0_q) - 18'(w1_q) - 18'(w2_q) + 18'(w3_q);
				lin_n = 18'(w1_q) - 18'(w0_q) - 18'(w2_q) + 18'(w3_q);
				shx = 6'd2;
			end
			default: begin
				shx = 6'd0;
			end
		endcase
	end

	assign l_eff = (body_q == 16'd0) ? 16'd1 : body_q;
	assign s_eff = (span_q == 16'd0) ? 16'd1 : span_q;

	always_comb begin
		case (kind_q)
			KIND_THREE:   divr = {2'b00, l_eff} + {1'b0, l_eff, 1'b0};
			KIND_MECANUM: divr = {s_eff, 2'b00};
			default:      divr = {l_eff, 2'b00};
		endcase
	end

	// ---------------- shared multiplier ----------------
	logic signed [35:0] mul_a;
	logic signed [22:0] mul_b;
	logic signed [58:0] mul_p;
	logic signed [22:0] r23;
	logic signed [35:0] mag;
	logic signed [35:0] rxh, rxl, ryh, ryl;

	assign r23 = signed'({7'd0, rad_q});
	assign mag = num_q[35] ? -num_q : num_q;
	assign rxh = 36'(rx_q >>> 19);
	assign ryh = 36'(ry_q >>> 19);
	assign rxl = signed'({17'd0, rx_q[18:0]});
	assign ryl = signed'({17'd0, ry_q[18:0]});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_KIN: begin
				if (is_three) begin
					case (cnt_q)
						6'd0: begin mul_a = 36'(w0_q); mul_b = r23; end
						6'd1: begin mul_a = 36'(w1_q); mul_b = r23; end
						6'd2: begin mul_a = 36'(w2_q); mul_b = r23; end
						6'd3: begin mul_a = 36'(t0_q); mul_b = COS75; end
						6'd4: begin mul_a = 36'(t1_q); mul_b = COS45; end
						6'd5: begin mul_a = 36'(t2_q); mul_b = COS15; end
						6'd6: begin mul_a = 36'(t0_q); mul_b = COS15; end
						6'd7: begin mul_a = 36'(t1_q); mul_b = COS45; end
						default: begin mul_a = 36'(t2_q); mul_b = COS75; end
					endcase
				end else begin
					case (cnt_q)
						6'd0: mul_a = 36'(lin_x);
						6'd1: mul_a = 36'(lin_y);
						default: mul_a = 36'(lin_n);
					endcase
					mul_b = r23;
				end
			end
			S_TURN: begin
				mul_a = mag;
				mul_b = (cnt_q == 6'd0) ? DEG_K_HI : DEG_K_LO;
			end
			S_POS: begin
				case (cnt_q)
					6'd0: begin mul_a = rxh; mul_b = 23'(cos_q); end
					6'd1: begin mul_a = rxl; mul_b = 23'(cos_q); end
					6'd2: begin mul_a = ryh; mul_b = 23'(sin_q); end
					6'd3: begin mul_a = ryl; mul_b = 23'(sin_q); end
					6'd4: begin mul_a = ryh; mul_b = 23'(cos_q); end
					6'd5: begin mul_a = ryl; mul_b = 23'(cos_q); end
					6'd6: begin mul_a = rxh; mul_b = 23'(sin_q); end
					default: begin mul_a = rxl; mul_b = 23'(sin_q); end
				endcase
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign mul_p = 59'(mul_a) * 59'(mul_b);

	// ---------------- accumulation of products ----------------
	logic signed [63:0] p64, term, acc_sum;
	logic acc_start, acc_neg;
	logic [4:0] acc_sh;

	assign p64 = 64'(prod_q);

	always_comb begin
		acc_start = 1'b0;
		acc_neg = 1'b0;
		acc_sh = 5'd0;
		case (state_q)
			S_KIN: begin
				acc_start = (cnt_q == 6'd3) || (cnt_q == 6'd6);
				acc_neg = (cnt_q == 6'd5) || (cnt_q == 6'd6);
			end
			S_TURN: begin
				acc_start = (cnt_q == 6'd0);
				acc_sh = (cnt_q == 6'd0) ? 5'd14 : 5'd0;
			end
			S_POS: begin
				acc_start = (cnt_q == 6'd0) || (cnt_q == 6'd4);
				acc_neg = (cnt_q == 6'd2) || (cnt_q == 6'd3);
				acc_sh = cnt_q[0] ? 5'd0 : 5'd19;
			end
			default: begin
				acc_start = 1'b0;
			end
		endcase
		term = p64 <<< acc_sh;
		acc_sum = (acc_start ? 64'sd0 : acc64_q) + (acc_neg ? -term : term);
	end

	// turn dividend: floor((|p| + den/2) / 2^28)
	logic [63:0] turn_x;
	assign turn_x = 64'(acc_sum) + {19'd0, divr, 27'd0};

	// position rounding and saturation
	logic signed [63:0] pos_rnd;
	logic signed [33:0] sum_x, sum_y;
	logic signed [31:0] sat_x, sat_y;

	assign pos_rnd = (acc_sum + 64'sd34359738368) >>> 36;
	assign sum_x = 34'(acc_x_q) + 34'(pos_rnd);
	assign sum_y = 34'(acc_y_q) + 34'(pos_rnd);

	always_comb begin
		if (sum_x > 34'sd2147483647) begin
			sat_x = 32'sh7fffffff;
		end else if (sum_x < -34'sd2147483648) begin
			sat_x = 32'sh80000000;
		end else begin
			sat_x = sum_x[31:0];
		end
		if (sum_y > 34'sd2147483647) begin
			sat_y = 32'sh7fffffff;
		end else if (sum_y < -34'sd2147483648) begin
			sat_y = 32'sh80000000;
		end else begin
			sat_y = sum_y[31:0];
		end
	end

	// ---------------- divider and modulo step ----------------
	logic [18:0] trial;
	logic        trial_ok;
	logic [35:0] mod_cmp;
	logic        mod_ok;

	assign trial = {rem_q[17:0], quo_q[34]};
	assign trial_ok = trial >= {1'b0, divr};
	assign mod_cmp = 36'(FULL_TURN) << cnt_q[4:0];
	assign mod_ok = {1'b0, quo_q} >= mod_cmp;

	// ---------------- heading wrap ----------------
	logic signed [15:0] turn_t;
	logic signed [16:0] h_raw, h_wrap;

	assign turn_t = num_q[35] ? -signed'({1'b0, quo_q[14:0]}) : signed'({1'b0, quo_q[14:0]});

	always_comb begin
		if (yaw_kind) begin
			h_raw = 17'(yaw_q) + 17'sd11520;
		end else begin
			h_raw = 17'(acc_h_q) + 17'(turn_t) + 17'sd11520;
		end
		if (h_raw < 17'sd0) begin
			h_wrap = h_raw + 17'sd23040 - 17'sd11520;
		end else if (h_raw >= 17'sd23040) begin
			h_wrap = h_raw - 17'sd23040 - 17'sd11520;
		end else begin
			h_wrap = h_raw - 17'sd11520;
		end
	end

	// ---------------- CORDIC stage ----------------
	logic signed [32:0] xs, ys, at33, x_fin, y_fin, c_rnd, s_rnd;

	assign xs = x_q >>> cnt_q[4:0];
	assign ys = y_q >>> cnt_q[4:0];
	assign at33 = signed'({3'b000, atan_q24(cnt_q[4:0])});
	assign x_fin = flip_q ? -x_q : x_q;
	assign y_fin = flip_q ? -y_q : y_q;
	assign c_rnd = (x_fin + 33'sd512) >>> 10;
	assign s_rnd = (y_fin + 33'sd512) >>> 10;

	// ---------------- sequencer ----------------
	logic kin_last;
	assign kin_last = is_three ? (cnt_q == 6'd8) : (cnt_q == 6'd2);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = move_kind ? S_KIN : S_DONE;
				end
			end
			S_KIN: begin
				if (ph_q && kin_last) begin
					state_d = yaw_kind ? S_HEAD : S_TURN;
				end
			end
			S_TURN: begin
				if (ph_q && (cnt_q == 6'd1)) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (cnt_q == 6'd0) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD:   state_d = S_CSET;
			S_CSET:   state_d = S_CORDIC;
			S_CORDIC: begin
				if (cnt_q == CORDIC_LAST) begin
					state_d = S_CFIN;
				end
			end
			S_CFIN:   state_d = S_POS;
			S_POS: begin
				if (ph_q && (cnt_q == 6'd7)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ph_q <= 1'b0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_h_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					ph_q <= 1'b0;
				end
				S_KIN, S_TURN, S_POS: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						cnt_q <= (state_d == state_q) ? cnt_q + 6'd1 : '0;
					end
					if (ph_q && (state_q == S_POS) && (cnt_q == 6'd3)) begin
						acc_x_q <= sat_x;
					end
					if (ph_q && (state_q == S_POS) && (cnt_q == 6'd7)) begin
						acc_y_q <= sat_y;
					end
				end
				S_DIV: begin
					cnt_q <= (cnt_q == DIV_LAST) ? MOD_FIRST : cnt_q + 6'd1;
				end
				S_MOD: begin
					cnt_q <= cnt_q - 6'd1;
				end
				S_HEAD: begin
					acc_h_q <= h_wrap[15:0];
					cnt_q <= '0;
				end
				S_CSET: begin
					cnt_q <= '0;
				end
				S_CORDIC: begin
					cnt_q <= cnt_q + 6'd1;
				end
				S_CFIN: begin
					cnt_q <= '0;
					ph_q <= 1'b0;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// datapath registers
	logic signed [15:0] h_fold;
	assign h_fold = (acc_h_q > 16'sd5760) ? acc_h_q - 16'sd11520 :
		(acc_h_q < -16'sd5760) ? acc_h_q + 16'sd11520 : acc_h_q;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_acc) begin
			w0_q <= s_tdata[15:0];
			w1_q <= s_tdata[31:16];
			w2_q <= s_tdata[47:32];
			w3_q <= s_tdata[63:48];
			yaw_q <= s_tdata[78:64];
		end
		case (state_q)
			S_KIN: begin
				if (ph_q) begin
					if (is_three) begin
						case (cnt_q)
							6'd0: t0_q <= prod_q[33:0];
							6'd1: t1_q <= prod_q[33:0];
							6'd2: t2_q <= prod_q[33:0];
							6'd5: begin
								acc64_q <= acc_sum;
								rx_q <= 38'(acc_sum >>> 12);
							end
							6'd8: begin
								acc64_q <= acc_sum;
								ry_q <= 38'(acc_sum >>> 12);
								num_q <= -(36'(t0_q) + 36'(t1_q) + 36'(t2_q));
							end
							default: acc64_q <= acc_sum;
						endcase
					end else begin
						case (cnt_q)
							6'd0: rx_q <= 38'(p64 <<< shx);
							6'd1: ry_q <= 38'(p64 <<< shx);
							default: num_q <= prod_q[35:0];
						endcase
					end
				end
			end
			S_TURN: begin
				if (ph_q) begin
					acc64_q <= acc_sum;
					if (cnt_q == 6'd1) begin
						quo_q <= turn_x[62:28];
						rem_q <= '0;
					end
				end
			end
			S_DIV: begin
				rem_q <= trial_ok ? trial - {1'b0, divr} : trial;
				quo_q <= {quo_q[33:0], trial_ok};
			end
			S_MOD: begin
				if (mod_ok) begin
					quo_q <= 35'({1'b0, quo_q} - mod_cmp);
				end
			end
			S_CSET: begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				z_q <= 33'(h_fold) <<< 18;
				flip_q <= (acc_h_q > 16'sd5760) || (acc_h_q < -16'sd5760);
			end
			S_CORDIC: begin
				if (!z_q[32]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at33;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at33;
				end
			end
			S_CFIN: begin
				cos_q <= c_rnd[21:0];
				sin_q <= s_rnd[21:0];
			end
			S_POS: begin
				if (ph_q) begin
					acc64_q <= acc_sum;
				end
			end
			default: begin
				acc64_q <= acc64_q;
			end
		endcase
		if ((state_q == S_DONE) && out_free) begin
			ox_q <= acc_x_q;
			oy_q <= acc_y_q;
			oh_q <= acc_h_q[14:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, oh_q, oy_q, ox_q};

	// ---------------- configuration port ----------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
			rad_q <= 16'd0;
			body_q <= 16'd1;
			span_q <= 16'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_KIND:   kind_q <= pwdata[2:0];
				REG_RADIUS: rad_q <= pwdata[15:0];
				REG_BODY:   body_q <= pwdata[15:0];
				REG_SPAN:   span_q <= pwdata[15:0];
				default:    kind_q <= kind_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_KIND:   prdata = {29'd0, kind_q};
			REG_RADIUS: prdata = {16'd0, rad_q};
			REG_BODY:   prdata = {16'd0, body_q};
			REG_SPAN:   prdata = {16'd0, span_q};
			default:    prdata = 32'd0;
		endcase
	end

	// ---------------- assertions ----------------
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("request taken while previous one still in flight");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_h_q >= -16'sd11520) && (acc_h_q <= 16'sd11519))
		else $error("heading left its wrapped range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < {1'b0, divr}))
		else $error("divider remainder not below divisor");

	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_HEAD) && turn_kind) |-> (quo_q < 35'd23040))
		else $error("modulo reduction left an oversized turn");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && m_valid_q && !m_tready) |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

endmodule

// ===== tb/wheel_odometry_integrator_unit_tb.sv =====
`timescale 1ns / 1ps

module wheel_odometry_integrator_unit_tb;
	import woi_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam int RUN_LIMIT    = 600000;
	localparam int SETTLE       = 160;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [14:0] head;
	} pose_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// wheel_a[15:0], wheel_b[31:16], wheel_c[47:32], wheel_d[63:48], yaw_in[78:64]
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// pos_x[31:0], pos_y[63:32], heading_out[78:64]
	logic [79:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// mirror of the block's registers and accumulators
	logic [2:0]  cur_kind;
	logic [15:0] cur_radius;
	logic [15:0] cur_body;
	logic [15:0] cur_span;
	longint      est_x;
	longint      est_y;
	longint      est_head;

	pose_t expected_poses[$];
	int    error_count;
	int    cycle_count;
	bit    idle_on;

	longint atan_table[24] = '{
		754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	wheel_odometry_integrator_unit #(.CORDIC_STEPS(CORDIC_STEPS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint wrap_angle(input longint v);
		longint r;
		r = ((v + HALF_TURN) % FULL_TURN + FULL_TURN) % FULL_TURN;
		return r - HALF_TURN;
	endfunction

	function automatic longint sat_word(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// radians numerator over divisor, to 1/64 degree, halves away from zero
	function automatic longint turn_to_units(input longint num, input longint div);
		longint p, den, mag, q;
		p = num * 64'sd240315917;
		den = div * 64'sd268435456;
		mag = (p < 0) ? -p : p;
		q = (mag + den / 2) / den;
		return (p < 0) ? -q : q;
	endfunction

	task automatic rotate_terms(input longint h, output longint c, output longint s);
		bit     flip;
		longint x, y, z, nx;
		int     steps;
		flip = 0;
		x = 652032874;
		y = 0;
		steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
		if (h > QUARTER_TURN) begin
			h -= HALF_TURN;
			flip = 1;
		end else if (h < -QUARTER_TURN) begin
			h += HALF_TURN;
			flip = 1;
		end
		z = h * 262144;
		for (int i = 0; i < steps; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_table[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_table[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + 512) >>> 10;
		s = (y + 512) >>> 10;
	endtask

	task automatic predict_pose(input logic [79:0] req);
		longint w0, w1, w2, w3, yaw, r, l, sp, rx, ry, c, s, dx, dy;
		bit     moves;
		pose_t  p;
		w0 = longint'($signed(req[15:0]));
		w1 = longint'($signed(req[31:16]));
		w2 = longint'($signed(req[47:32]));
		w3 = longint'($signed(req[63:48]));
		yaw = longint'($signed(req[78:64]));
		r = longint'(cur_radius);
		l = (cur_body == 0) ? 1 : longint'(cur_body);
		sp = (cur_span == 0) ? 1 : longint'(cur_span);
		rx = 0;
		ry = 0;
		moves = 1;
		case (cur_kind)
			KIND_TWO_WHEEL: begin
				rx = r * (w0 + w1) * 8;
				est_head = wrap_angle(yaw);
			end
			KIND_TWO_OMNI: begin
				rx = r * w0 * 16;
				ry = r * w1 * 16;
				est_head = wrap_angle(yaw);
			end
			KIND_THREE: begin
				rx = (r * (w0 * 16962 + w1 * 46341 - w2 * 63303)) >>> 12;
				ry = (r * (-w0 * 63303 + w1 * 46341 + w2 * 16962)) >>> 12;
				est_head = wrap_angle(est_head +
					turn_to_units(-(r * (w0 + w1 + w2)), 3 * l) % FULL_TURN);
			end
			KIND_FOUR: begin
				rx = r * (w3 - w1) * 16;
				ry = r * (w0 - w2) * 16;
				est_head = wrap_angle(est_head +
					turn_to_units(r * (w0 + w1 + w2 + w3), 4 * l) % FULL_TURN);
			end
			KIND_MECANUM: begin
				rx = r * (w0 + w1 + w2 + w3) * 4;
				ry = r * (w0 - w1 - w2 + w3) * 4;
				est_head = wrap_angle(est_head +
					turn_to_units(r * (w1 - w0 - w2 + w3), 4 * sp) % FULL_TURN);
			end
			default: moves = 0;
		endcase
		if (moves) begin
			rotate_terms(est_head, c, s);
			dx = (rx * c - ry * s + (64'sd1 <<< 35)) >>> 36;
			dy = (ry * c + rx * s + (64'sd1 <<< 35)) >>> 36;
			est_x = sat_word(est_x + dx);
			est_y = sat_word(est_y + dy);
		end
		p.x = est_x[31:0];
		p.y = est_y[31:0];
		p.head = est_head[14:0];
		expected_poses.push_back(p);
	endtask

	// result checker
	always @(posedge clk) begin
		pose_t p;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_poses.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				error_count++;
			end else begin
				p = expected_poses.pop_front();
				if (m_tdata[31:0] !== p.x) begin
					$display("%0t: pos_x expected %0d actual %0d", $time, p.x,
						$signed(m_tdata[31:0]));
					error_count++;
				end
				if (m_tdata[63:32] !== p.y) begin
					$display("%0t: pos_y expected %0d actual %0d", $time, p.y,
						$signed(m_tdata[63:32]));
					error_count++;
				end
				if (m_tdata[78:64] !== p.head) begin
					$display("%0t: heading expected %0d actual %0d", $time,
						$signed(p.head), $signed(m_tdata[78:64]));
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KIND:   cur_kind = val[2:0];
			REG_RADIUS: cur_radius = val;
			REG_BODY:   cur_body = val;
			default:    cur_span = val;
		endcase
	endtask

	task automatic wait_drained();
		// drop valid so the last request is not taken again
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_poses.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic setup(input logic [2:0] kind, input logic [15:0] rad,
			input logic [15:0] body, input logic [15:0] span);
		wait_drained();
		write_reg(REG_KIND, {13'h0, kind});
		write_reg(REG_RADIUS, rad);
		write_reg(REG_BODY, body);
		write_reg(REG_SPAN, span);
	endtask

	task automatic send_request(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d, input logic [14:0] yaw);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tdata <= {1'b0, yaw, d, c, b, a};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!(s_tvalid && s_tready))
			@(posedge clk);
		predict_pose(s_tdata);
	endtask

	task automatic send_random();
		send_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			15'($urandom));
	endtask

	task automatic test_reset_hold();
		// kind none after reset: state held
		send_request(16'h7fff, 16'h8000, 16'h1234, 16'hffff, 15'd100);
		send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h4000);
	endtask

	task automatic test_directed_kinds();
		for (int k = KIND_TWO_WHEEL; k <= KIND_MECANUM; k++) begin
			setup(k[2:0], 16'd1600, 16'd3200, 16'd4000);
			send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'd11520);
			send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, -15'sd11520);
			send_request(16'h1000, 16'hf000, 16'h0800, 16'h0400, 15'd5761);
		end
		// yaw outside the nominal range wraps
		setup(KIND_TWO_OMNI, 16'd800, 16'd1, 16'd1);
		send_request(16'h0400, 16'h0200, 16'h0, 16'h0, 15'h3fff);
		send_request(16'h0400, 16'h0200, 16'h0, 16'h0, 15'h4000);
		// zero radius: yaw still copied, no motion
		setup(KIND_TWO_WHEEL, 16'd0, 16'd0, 16'd0);
		send_request(16'h7fff, 16'h7fff, 16'h0, 16'h0, 15'd5760);
		// zero divisors act as one, here with a huge radius
		setup(KIND_FOUR, 16'hffff, 16'd0, 16'd0);
		send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'd0);
		setup(KIND_MECANUM, 16'hffff, 16'hffff, 16'd0);
		send_request(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 15'd0);
		setup(3'd6, 16'hffff, 16'hffff, 16'hffff);
		send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'd0);
		setup(3'd7, 16'd5, 16'd5, 16'd5);
		send_request(16'h7fff, 16'h0, 16'h0, 16'h0, 15'd0);
	endtask

	task automatic test_random_phases();
		logic [15:0] rad;
		for (int ph = 0; ph < 16; ph++) begin
			rad = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
			setup(3'($urandom_range(0, 7)), rad, $urandom_range(0, 7) == 0 ? 16'hffff :
				16'($urandom_range(0, 4000)), 16'($urandom));
			if (ph == 15)
				idle_on = 0;
			for (int n = 0; n < 26; n++) begin
				send_random();
				// hold off until every result is back
				if (ph == 4 && n == 10)
					wait_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1;
		error_count = 0;
		cycle_count = 0;
		cur_kind = KIND_NONE;
		cur_radius = 16'd0;
		cur_body = 16'd1;
		cur_span = 16'd1;
		est_x = 0;
		est_y = 0;
		est_head = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_hold();
		test_directed_kinds();
		test_random_phases();

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
